[rtl/pstq_pkg.sv]
// ----------------------------------------------------------------------------
// pstq_pkg: shared types and constants for the sorted transmit queue
// Holds field widths, result status codes, controller states and the
// command and status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pstq_pkg;

  localparam int BUNDLE_W = 16;
  localparam int PRIO_W   = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int LEN_W    = 5;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_QUEUED    = 2'd0,
    STATUS_DUPLICATE = 2'd1,
    STATUS_REJECTED  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

[rtl/pstq_req_if.sv]
// ----------------------------------------------------------------------------
// pstq_req_if: insert request channel
// Carries one bundle index and its priority per transfer.
// ----------------------------------------------------------------------------
interface pstq_req_if;
  logic                                valid;
  logic                                ready;
  logic [pstq_pkg::BUNDLE_W-1:0]       bundle_index;
  logic signed [pstq_pkg::PRIO_W-1:0]  priority_req;

  modport source (output valid, output bundle_index, output priority_req, input ready);
  modport sink (input valid, input bundle_index, input priority_req, output ready);
endinterface

[rtl/pstq_rsp_if.sv]
// ----------------------------------------------------------------------------
// pstq_rsp_if: insert result channel
// Carries the outcome of one insert and the queue state after it.
// ----------------------------------------------------------------------------
interface pstq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [pstq_pkg::STATUS_W-1:0]  status;
  logic [pstq_pkg::POS_W-1:0]     position;
  logic [pstq_pkg::LEN_W-1:0]     queue_length;
  logic                           overflow;
  logic [pstq_pkg::BUNDLE_W-1:0]  head_bundle;

  modport source (output valid, output status, output position, output queue_length,
                  output overflow, output head_bundle, input ready);
  modport sink (input valid, input status, input position, input queue_length,
                input overflow, input head_bundle, output ready);
endinterface

[rtl/pstq_ctrl.sv]
// ----------------------------------------------------------------------------
// pstq_ctrl: insert sequencer
// Steps each request through load, compare and update, and holds the
// update while the result register is still occupied.
// ----------------------------------------------------------------------------
module pstq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  pstq_pkg::stat_t stat,
  output pstq_pkg::cmd_t  cmd
);

  pstq_pkg::state_t state;
  pstq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pstq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pstq_pkg::ST_IDLE: begin
        if (req_valid) state_next = pstq_pkg::ST_CMP;
      end
      pstq_pkg::ST_CMP: begin
        state_next = pstq_pkg::ST_UPD;
      end
      pstq_pkg::ST_UPD: begin
        if (stat.out_free) state_next = pstq_pkg::ST_IDLE;
      end
      default: begin
        state_next = pstq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    cmd.load    = 1'b0;
    cmd.compare = 1'b0;
    cmd.update  = 1'b0;
    case (state)
      pstq_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      pstq_pkg::ST_CMP: begin
        cmd.compare = 1'b1;
      end
      pstq_pkg::ST_UPD: begin
        cmd.update = stat.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/pstq_datapath.sv]
// ----------------------------------------------------------------------------
// pstq_datapath: queue slots, per-slot comparators and result register
// Every slot compares itself against the request; the update then moves
// each slot from its own and its neighbour's flags and two shared summaries, keeping the queue sorted.
// ----------------------------------------------------------------------------
module pstq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int INDEX_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pstq_pkg::cmd_t                      cmd,
  output pstq_pkg::stat_t                     stat,
  input  logic [pstq_pkg::BUNDLE_W-1:0]       bundle_index,
  input  logic signed [pstq_pkg::PRIO_W-1:0]  priority_req,
  pstq_rsp_if.source                          rsp
);

  localparam int KeyW = (INDEX_BITS < pstq_pkg::BUNDLE_W) ? INDEX_BITS : pstq_pkg::BUNDLE_W;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [KeyW-1:0]                    slot_bundle [QUEUE_DEPTH];
  logic signed [pstq_pkg::PRIO_W-1:0] slot_prio   [QUEUE_DEPTH];
  logic [KeyW-1:0]                    up_bundle   [QUEUE_DEPTH];
  logic signed [pstq_pkg::PRIO_W-1:0] up_prio     [QUEUE_DEPTH];

  logic [KeyW-1:0]                    key;
  logic signed [pstq_pkg::PRIO_W-1:0] prio;
  logic [QUEUE_DEPTH-1:0]             hit;
  logic [QUEUE_DEPTH-1:0]             lt;
  logic [CntW-1:0]                    fill_count;
  logic                               overflow_flag;

  logic [QUEUE_DEPTH-1:0] valid_vec;
  logic [QUEUE_DEPTH-1:0] valid_prev;
  logic [QUEUE_DEPTH-1:0] lt_prev;
  logic [QUEUE_DEPTH-1:0] ins_vec;
  logic [QUEUE_DEPTH-1:0] shift_vec;
  logic [QUEUE_DEPTH-1:0] sel_vec;
  logic                   dup;
  logic                   any_lt;
  logic                   placed;
  logic                   full;
  logic [CntW-1:0]        pos_enc;
  logic [CntW-1:0]        pos_next;
  logic [CntW-1:0]        fill_count_next;
  logic                   overflow_flag_next;
  logic [KeyW-1:0]        head_key;
  logic [31:0]            pos_wide;
  logic [31:0]            len_wide;
  pstq_pkg::status_t      status_next;

  // A slot holds a live entry when it lies below the fill count.
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      valid_vec[k] = CntW'(k) < fill_count;
    end
  end

  assign valid_prev = (valid_vec << 1) | QUEUE_DEPTH'(1);
  assign lt_prev    = lt << 1;
  assign dup        = |hit;
  assign any_lt     = |lt;
  assign full       = (fill_count == CntW'(QUEUE_DEPTH));

  // The new entry lands at the first outranked slot, or appends when no
  // live slot is outranked. Every slot behind an outranked one moves back.
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      ins_vec[k]   = !dup && ((lt[k] && !lt_prev[k]) ||
                              (!any_lt && !valid_vec[k] && valid_prev[k]));
      shift_vec[k] = !dup && lt_prev[k];
    end
  end

  always_comb begin
    up_bundle[0] = key;
    up_prio[0]   = prio;
    for (int k = 1; k < QUEUE_DEPTH; k++) begin
      up_bundle[k] = slot_bundle[k-1];
      up_prio[k]   = slot_prio[k-1];
    end
  end

  assign placed  = |ins_vec;
  assign sel_vec = dup ? hit : ins_vec;

  always_comb begin
    pos_enc = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      if (sel_vec[k]) pos_enc = pos_enc | CntW'(k);
    end
  end

  always_comb begin
    if (dup) begin
      status_next = pstq_pkg::STATUS_DUPLICATE;
    end else if (placed) begin
      status_next = pstq_pkg::STATUS_QUEUED;
    end else begin
      status_next = pstq_pkg::STATUS_REJECTED;
    end
  end

  assign pos_next           = (dup || placed) ? pos_enc : CntW'(QUEUE_DEPTH);
  assign fill_count_next    = (placed && !full) ? fill_count + CntW'(1) : fill_count;
  assign overflow_flag_next = overflow_flag | (!dup && full);
  assign head_key           = ins_vec[0] ? key : slot_bundle[0];
  assign pos_wide           = 32'(pos_next);
  assign len_wide           = 32'(fill_count_next);

  assign stat.out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key  <= bundle_index[KeyW-1:0];
      prio <= priority_req;
    end
    if (cmd.compare) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        hit[k] <= valid_vec[k] && (slot_bundle[k] == key);
        lt[k]  <= valid_vec[k] && (slot_prio[k] < prio);
      end
    end
    if (cmd.update) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        if (ins_vec[k]) begin
          slot_bundle[k] <= key;
          slot_prio[k]   <= prio;
        end else if (shift_vec[k]) begin
          slot_bundle[k] <= up_bundle[k];
          slot_prio[k]   <= up_prio[k];
        end
      end
      rsp.status       <= status_next;
      rsp.position     <= pos_wide[pstq_pkg::POS_W-1:0];
      rsp.queue_length <= len_wide[pstq_pkg::LEN_W-1:0];
      rsp.overflow     <= overflow_flag_next;
      rsp.head_bundle  <= (fill_count_next != '0) ? pstq_pkg::BUNDLE_W'(head_key) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      overflow_flag <= 1'b0;
      rsp.valid     <= 1'b0;
    end else begin
      if (cmd.update) begin
        fill_count    <= fill_count_next;
        overflow_flag <= overflow_flag_next;
        rsp.valid     <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid     <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CntW'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> $onehot0(hit))
    else $error("bundle held in more than one slot");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> $onehot0(lt & ~(lt << 1)))
    else $error("outranked slots do not form one run, queue not sorted");

  a_result: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> rsp.valid)
    else $error("update did not present a result");

endmodule

[rtl/priority_sorted_tx_queue_insert.sv]
// ----------------------------------------------------------------------------
// priority_sorted_tx_queue_insert: sorted transmit queue, insert side
// Keeps bundle indices ordered by descending priority with per-slot compare.
// ----------------------------------------------------------------------------
// Order: the request transfer latches the request, the compare step then
// registers the per-slot flags, and the update step loads the result
// register, later only if the result register still waits.
// A new request is taken only once the current one has passed its load,
// compare and update steps through the slot row.
// Reset empties the queue through the fill count and clears the overflow flag.
// ----------------------------------------------------------------------------
module priority_sorted_tx_queue_insert #(
  parameter int QUEUE_DEPTH = 16,
  parameter int INDEX_BITS  = 16
) (
  input logic        clk,
  input logic        rst,
  pstq_req_if.sink   req,
  pstq_rsp_if.source rsp
);

  // The controller walks each request through three steps. On the first,
  // the request transfer latches the bundle index (kept to INDEX_BITS bits)
  // and priority. On the second, every slot compares itself against the
  // request in parallel: a bundle match marks a duplicate, and a lower
  // stored priority marks an outranked slot. Because the queue is sorted,
  // outranked slots form one run at the tail of the live entries.
  pstq_pkg::cmd_t  cmd;
  pstq_pkg::stat_t stat;
  logic            req_ready;

  // On the third step the new entry lands at the head of that run, or is
  // appended when nothing is outranked. Entries behind it move back one
  // slot, and in a full queue the last entry falls off and sets overflow.
  // A full queue with nothing outranked rejects the request and also sets
  // overflow. The result register lets the next request transfer while a
  // result still waits; the update step holds until that register is free.
  assign req.ready = req_ready;

  pstq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pstq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .bundle_index (req.bundle_index),
    .priority_req (req.priority_req),
    .rsp          (rsp)
  );

endmodule

[test/priority_sorted_tx_queue_insert_tb.sv]
// ----------------------------------------------------------------------------
// priority_sorted_tx_queue_insert_tb: self-checking bench for the sorted queue
// Drives insert requests with random gaps, takes results under random and long
// stalls, and checks every result field against a local model of the queue.
// ----------------------------------------------------------------------------
module priority_sorted_tx_queue_insert_tb;

  localparam int DEPTH    = 16;
  localparam int IDX_BITS = 16;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 200;
  // The block takes each insert through load, compare and update; this covers
  // the tail after the last transfer with room to spare.
  localparam int TAIL_CYCLES = 8;
  // Length, in cycles, of the long receiver hold-offs after the 300th and 900th results.
  localparam int HOLD_CYCLES = 200;

  localparam logic signed [pstq_pkg::PRIO_W-1:0] PRIO_MIN = 32'sh8000_0000;
  localparam logic signed [pstq_pkg::PRIO_W-1:0] PRIO_MAX = 32'sh7FFF_FFFF;

  // One insert request waiting to be offered, with the idle cycles the sender
  // spends before it and whether the sender first waits for all results.
  typedef struct {
    logic [pstq_pkg::BUNDLE_W-1:0]        bundle;
    logic signed [pstq_pkg::PRIO_W-1:0]   prio;
    int                                   gap;
    bit                                   drain;
  } insert_req_t;

  // What one insert should report.
  typedef struct {
    pstq_pkg::status_t                    status;
    logic [pstq_pkg::POS_W-1:0]           position;
    logic [pstq_pkg::LEN_W-1:0]           length;
    logic                                 overflow;
    logic [pstq_pkg::BUNDLE_W-1:0]        head;
  } insert_outcome_t;

  logic clk = 1'b0;
  logic rst;

  pstq_req_if req_ch ();
  pstq_rsp_if rsp_ch ();

  priority_sorted_tx_queue_insert #(
    .QUEUE_DEPTH(DEPTH),
    .INDEX_BITS (IDX_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  always #1 clk = ~clk;

  // Requests still to be offered, and outcomes predicted for accepted requests
  // whose results have not been taken yet.
  insert_req_t     insert_backlog[$];
  insert_outcome_t predicted_outcomes[$];

  int errors       = 0;
  int results_done = 0;

  // Transfers seen at the last rising edge, for the falling-edge drivers.
  logic req_taken = 1'b0;
  logic rsp_taken = 1'b0;

  // Local copy of the queue. Only slots below sq_fill are ever read.
  logic [pstq_pkg::BUNDLE_W-1:0]      sq_bundle[DEPTH];
  logic signed [pstq_pkg::PRIO_W-1:0] sq_prio[DEPTH];
  int                                 sq_fill     = 0;
  logic                               sq_overflow = 1'b0;

  // Applies one insert to the local queue and returns what the block should
  // report for it. A bundle already queued changes nothing. A new entry goes
  // in front of the first entry with a strictly lower priority, so equal
  // priorities keep their arrival order. When the queue is full the lowest
  // entry falls off the end, or the insert is rejected if it outranks nothing.
  function automatic insert_outcome_t apply_insert(
      logic [pstq_pkg::BUNDLE_W-1:0] bundle,
      logic signed [pstq_pkg::PRIO_W-1:0] prio);
    insert_outcome_t res;
    int dup_at;
    int slot;
    int last;
    dup_at = -1;
    for (int k = 0; k < sq_fill; k++) begin
      if (dup_at < 0 && sq_bundle[k] == bundle) dup_at = k;
    end
    if (dup_at >= 0) begin
      res.status   = pstq_pkg::STATUS_DUPLICATE;
      res.position = pstq_pkg::POS_W'(dup_at);
    end else begin
      slot = sq_fill;
      for (int k = sq_fill - 1; k >= 0; k--) begin
        if (sq_prio[k] < prio) slot = k;
      end
      if (slot < DEPTH) begin
        if (sq_fill == DEPTH) begin
          last        = DEPTH - 1;
          sq_overflow = 1'b1;
        end else begin
          last = sq_fill;
        end
        for (int k = last; k > slot; k--) begin
          sq_bundle[k] = sq_bundle[k-1];
          sq_prio[k]   = sq_prio[k-1];
        end
        sq_bundle[slot] = bundle;
        sq_prio[slot]   = prio;
        if (sq_fill < DEPTH) sq_fill++;
        res.status   = pstq_pkg::STATUS_QUEUED;
        res.position = pstq_pkg::POS_W'(slot);
      end else begin
        sq_overflow  = 1'b1;
        res.status   = pstq_pkg::STATUS_REJECTED;
        res.position = pstq_pkg::POS_W'(DEPTH);
      end
    end
    res.length   = pstq_pkg::LEN_W'(sq_fill);
    res.overflow = sq_overflow;
    res.head     = (sq_fill > 0) ? sq_bundle[0] : '0;
    return res;
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  task automatic plan_insert(input logic [pstq_pkg::BUNDLE_W-1:0] bundle,
                             input logic signed [pstq_pkg::PRIO_W-1:0] prio,
                             input int gap, input bit drain);
    insert_req_t item;
    item.bundle = bundle;
    item.prio   = prio;
    item.gap    = gap;
    item.drain  = drain;
    insert_backlog.push_back(item);
  endtask

  // Monitor: at each rising edge a request transfer is run through the local
  // queue, and a result transfer is checked against the oldest prediction.
  always @(posedge clk) begin : monitor
    insert_outcome_t want;
    if (rst) begin
      req_taken <= 1'b0;
      rsp_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      rsp_taken <= rsp_ch.valid && rsp_ch.ready;
      if (req_ch.valid && req_ch.ready)
        predicted_outcomes.push_back(apply_insert(req_ch.bundle_index, req_ch.priority_req));
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_done <= results_done + 1;
        if (predicted_outcomes.size() == 0) begin
          errors++;
          $display("%0t: result with no pending insert, expected none, actual status %0h",
                   $time, rsp_ch.status);
        end else begin
          want = predicted_outcomes.pop_front();
          check_field("status", want.status, rsp_ch.status);
          check_field("position", want.position, rsp_ch.position);
          check_field("queue_length", want.length, rsp_ch.queue_length);
          check_field("overflow", want.overflow, rsp_ch.overflow);
          check_field("head_bundle", want.head, rsp_ch.head_bundle);
        end
      end
    end
  end

  // Sender: works at the falling edge. A request stays on the bus until its
  // transfer; after that the sender idles for the gap of the next request,
  // and a request marked for draining waits until no result is outstanding.
  int tx_gap = 0;

  always @(negedge clk) begin : sender
    insert_req_t item;
    if (!rst) begin
      if (req_ch.valid && !req_taken) begin
        // Still waiting for the block to take the current request.
      end else begin
        if (req_ch.valid && insert_backlog.size() > 0) tx_gap = insert_backlog[0].gap;
        if (tx_gap > 0) begin
          req_ch.valid <= 1'b0;
          tx_gap--;
        end else if (insert_backlog.size() > 0 &&
                     !(insert_backlog[0].drain && predicted_outcomes.size() != 0)) begin
          item = insert_backlog.pop_front();
          req_ch.bundle_index <= item.bundle;
          req_ch.priority_req <= item.prio;
          req_ch.valid        <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: after each result transfer it draws a random stall, except in
  // calm stretches. Twice in the run it holds ready low for a long
  // stretch so that the block backs up and stalls the request side.
  int rx_stall = 0;
  int rx_hold  = 0;
  bit rx_calm  = 1'b0;

  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_taken) begin
        if (results_done % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        rx_stall = rx_calm ? 0 : int'($urandom_range(0, 5));
        if (results_done == 300 || results_done == 900) rx_hold = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rsp_ch.ready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        rsp_ch.ready <= 1'b0;
        rx_stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #400000;
    $display("priority_sorted_tx_queue_insert_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [pstq_pkg::BUNDLE_W-1:0]      b;
    logic signed [pstq_pkg::PRIO_W-1:0] p;
    logic signed [pstq_pkg::PRIO_W-1:0] prev_p;
    longint                             climb;
    int                                 sel;
    bit                                 calm;

    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.bundle_index = '0;
    req_ch.priority_req = '0;
    rsp_ch.ready        = 1'b0;

    // Directed part, starting from the empty queue.
    plan_insert(16'h0000, 0, 0, 1'b0);          // first entry
    plan_insert(16'h0000, 100, 1, 1'b0);        // duplicate keeps old priority
    plan_insert(16'hFFFF, PRIO_MAX, 0, 1'b0);   // new head
    plan_insert(16'h1234, PRIO_MIN, 2, 1'b0);   // lowest possible priority
    plan_insert(16'h0001, 0, 0, 1'b0);          // tie goes behind the older entry
    plan_insert(16'h8000, -1, 0, 1'b0);
    plan_insert(16'h7FFF, 1, 3, 1'b0);
    plan_insert(16'h1234, 50, 0, 1'b0);         // duplicate found in the last slot
    for (int k = 0; k < 10; k++)
      plan_insert(pstq_pkg::BUNDLE_W'(16'h0100 + k), k * 7 - 20, k % 3, 1'b0);
    // The queue is full from here on.
    plan_insert(16'h5555, PRIO_MIN, 0, 1'b0);   // outranks nothing, rejected
    plan_insert(16'hFFFF, 0, 0, 1'b0);          // duplicate at the head
    plan_insert(16'hAAAA, PRIO_MAX, 0, 1'b0);   // ties the head, lowest drops off
    plan_insert(16'h1234, PRIO_MIN + 1, 1, 1'b0);
    plan_insert(16'h1234, PRIO_MAX - 1, 0, 1'b0); // dropped bundle comes back
    plan_insert(16'h00FF, 32'sh4000_0000, 0, 1'b0);

    // Random part. The queue never drains, so most priorities ride a rising
    // ramp that keeps outranking the tail; repeats of the previous priority
    // give ties, and a small pool of bundles gives frequent duplicates.
    climb  = -64'sd2147483648 + 64'sd16777216;
    prev_p = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = (ph == 1 || ph == 4);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        sel = $urandom_range(0, 9);
        if (sel <= 4)      b = pstq_pkg::BUNDLE_W'($urandom_range(0, 23));
        else if (sel == 5) b = pstq_pkg::BUNDLE_W'($urandom_range(0, 65535));
        else if (sel == 6) b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else               b = pstq_pkg::BUNDLE_W'($urandom_range(0, 63));

        sel = $urandom_range(0, 19);
        if (sel == 0)      p = PRIO_MIN;
        else if (sel == 1) p = int'($urandom_range(0, 16)) - 8;
        else if (sel <= 3) p = pstq_pkg::PRIO_W'($urandom);
        else if (sel <= 6) p = prev_p;
        else               p = pstq_pkg::PRIO_W'(climb + $urandom_range(0, 7));
        climb  = climb + 64'h2C_0000;
        prev_p = p;

        // Phases two and four open with a pause until every result is in.
        plan_insert(b, p, calm ? 0 : int'($urandom_range(0, 5)),
                    i == 0 && (ph == 2 || ph == 4));
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Everything offered, taken, and answered.
    while (insert_backlog.size() != 0 || req_ch.valid || predicted_outcomes.size() != 0)
      @(posedge clk);
    // Leave room for any stray result after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("priority_sorted_tx_queue_insert_tb OK");
    end else begin
      $display("priority_sorted_tx_queue_insert_tb NOT OK");
    end
    $finish;
  end

endmodule
